>>> rtl/tgad_pkg.sv
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and codes of the TGA byte stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

	localparam logic [2:0] ST_PIXEL     = 3'd0;
	localparam logic [2:0] ST_HEADER    = 3'd1;
	localparam logic [2:0] ST_COLORMAP  = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
	localparam logic [2:0] ST_BAD_DEPTH = 3'd4;
	localparam logic [2:0] ST_BAD_ALPHA = 3'd5;

	localparam logic [1:0] KIND_GREY = 2'd0;
	localparam logic [1:0] KIND_RGB  = 2'd1;
	localparam logic [1:0] KIND_RGBA = 2'd2;

	localparam logic [7:0] TYPE_RAW_RGB  = 8'd2;
	localparam logic [7:0] TYPE_RAW_GREY = 8'd3;
	localparam logic [7:0] TYPE_RLE_RGB  = 8'd10;
	localparam logic [7:0] TYPE_RLE_GREY = 8'd11;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PACKET,
		PH_PIXEL,
		PH_DONE
	} phase_t;

	// classified item passed from the parser to the formatter
	typedef struct packed {
		logic [2:0]       status;
		logic [15:0]      width;
		logic [15:0]      height;
		logic [5:0]       depth;
		logic [3:0]       alpha;
		logic [1:0]       kind;
		logic [3:0][7:0]  bytes;
		logic [7:0]       rep;
		logic             last;
	} entry_t;

endpackage

>>> rtl/tgad_front.sv
// ----------------------------------------------------------------------------
// tgad_front
// Byte parser: header checks, ID skip, packet and pixel tracking.
// ----------------------------------------------------------------------------
module tgad_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [7:0]           data_byte,
	input  logic                 start_of_file,
	output logic                 emit,
	output tgad_pkg::entry_t     entry
);

	tgad_pkg::phase_t phase_q, phase_n, ph;
	logic [4:0]  hidx_q, hidx_n, hidx;
	logic [7:0]  skip_q, skip_n, skip;
	logic [15:0] width_q, width_n, width;
	logic [15:0] height_q, height_n, height;
	logic [5:0]  depth_q, depth_n, depth;
	logic [3:0]  alpha_q, alpha_n, alpha;
	logic [1:0]  kind_q, kind_n, kind;
	logic        rle_q, rle_n, rle;
	logic [31:0] left_q, left_n, left;
	logic        run_q, run_n, run;
	logic [7:0]  pkt_q, pkt_n, pkt;
	logic [1:0]  bip_q, bip_n, bip;
	logic [3:0][7:0] pb_q;
	logic [3:0][7:0] pbx;
	logic [2:0]  bpp;
	logic [7:0]  cnt;
	logic [7:0]  rep;
	logic [31:0] left_dec;
	logic [7:0]  pkt_dec;

	always_comb begin
		ph     = start_of_file ? tgad_pkg::PH_HEADER : phase_q;
		hidx   = start_of_file ? 5'd0 : hidx_q;
		skip   = start_of_file ? 8'd0 : skip_q;
		width  = start_of_file ? 16'd0 : width_q;
		height = start_of_file ? 16'd0 : height_q;
		depth  = start_of_file ? 6'd0 : depth_q;
		alpha  = start_of_file ? 4'd0 : alpha_q;
		kind   = start_of_file ? 2'd0 : kind_q;
		rle    = start_of_file ? 1'b0 : rle_q;
		left   = start_of_file ? 32'd0 : left_q;
		run    = start_of_file ? 1'b0 : run_q;
		pkt    = start_of_file ? 8'd0 : pkt_q;
		bip    = start_of_file ? 2'd0 : bip_q;

		pbx = pb_q;
		pbx[bip] = data_byte;

		bpp = depth[5:3];
		if (bpp == 3'd0) begin
			bpp = 3'd1;
		end else if (bpp > 3'd4) begin
			bpp = 3'd4;
		end

		cnt = {1'b0, data_byte[6:0]} + 8'd1;
		if (left < {24'd0, cnt}) begin
			cnt = left[7:0];
		end

		rep = (rle && run) ? pkt : 8'd1;
		if (rep == 8'd0) begin
			rep = 8'd1;
		end
		if (left < {24'd0, rep}) begin
			rep = left[7:0];
		end
		left_dec = left - {24'd0, rep};
		pkt_dec  = (pkt != 8'd0) ? pkt - 8'd1 : 8'd0;

		phase_n  = ph;
		hidx_n   = hidx;
		skip_n   = skip;
		width_n  = width;
		height_n = height;
		depth_n  = depth;
		alpha_n  = alpha;
		kind_n   = kind;
		rle_n    = rle;
		left_n   = left;
		run_n    = run;
		pkt_n    = pkt;
		bip_n    = bip;

		emit         = 1'b0;
		entry        = '0;
		entry.width  = width;
		entry.height = height;
		entry.depth  = depth;
		entry.alpha  = alpha;
		entry.kind   = kind;
		entry.bytes  = pbx;

		unique case (ph)
			tgad_pkg::PH_HEADER: begin
				if (hidx < 5'd31) begin
					hidx_n = hidx + 5'd1;
				end
				unique case (hidx)
					5'd0: skip_n = data_byte;
					5'd1: begin
						if (data_byte == 8'd1) begin
							emit         = 1'b1;
							entry.status = tgad_pkg::ST_COLORMAP;
							phase_n      = tgad_pkg::PH_DONE;
						end
					end
					5'd2: begin
						priority if (data_byte == tgad_pkg::TYPE_RAW_RGB) begin
							kind_n = tgad_pkg::KIND_RGB;
							rle_n  = 1'b0;
						end else if (data_byte == tgad_pkg::TYPE_RAW_GREY) begin
							kind_n = tgad_pkg::KIND_GREY;
							rle_n  = 1'b0;
						end else if (data_byte == tgad_pkg::TYPE_RLE_RGB) begin
							kind_n = tgad_pkg::KIND_RGB;
							rle_n  = 1'b1;
						end else if (data_byte == tgad_pkg::TYPE_RLE_GREY) begin
							kind_n = tgad_pkg::KIND_GREY;
							rle_n  = 1'b1;
						end else begin
							emit         = 1'b1;
							entry.status = tgad_pkg::ST_BAD_TYPE;
							phase_n      = tgad_pkg::PH_DONE;
						end
					end
					5'd12: width_n[7:0]   = data_byte;
					5'd13: width_n[15:8]  = data_byte;
					5'd14: height_n[7:0]  = data_byte;
					5'd15: height_n[15:8] = data_byte;
					5'd16: begin
						if (data_byte != 8'd8 && data_byte != 8'd16 &&
						    data_byte != 8'd24 && data_byte != 8'd32) begin
							emit         = 1'b1;
							entry.status = tgad_pkg::ST_BAD_DEPTH;
							phase_n      = tgad_pkg::PH_DONE;
						end else begin
							depth_n = data_byte[5:0];
							left_n  = width * height;
						end
					end
					5'd17: begin
						alpha_n = data_byte[3:0];
						emit    = 1'b1;
						if (data_byte[3:0] != 4'd0 && data_byte[3:0] != 4'd8) begin
							entry.status = tgad_pkg::ST_BAD_ALPHA;
							phase_n      = tgad_pkg::PH_DONE;
						end else begin
							if (kind == tgad_pkg::KIND_RGB && depth == 6'd32) begin
								kind_n = tgad_pkg::KIND_RGBA;
							end
							entry.status = tgad_pkg::ST_HEADER;
							entry.alpha  = data_byte[3:0];
							entry.kind   = kind_n;
							pkt_n        = 8'd0;
							run_n        = 1'b0;
							bip_n        = 2'd0;
							if (left == 32'd0) begin
								entry.last = 1'b1;
								phase_n    = tgad_pkg::PH_DONE;
							end else if (skip != 8'd0) begin
								phase_n = tgad_pkg::PH_SKIP;
							end else begin
								phase_n = rle ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXEL;
							end
						end
					end
					default: ;
				endcase
			end
			tgad_pkg::PH_SKIP: begin
				if (skip != 8'd0) begin
					skip_n = skip - 8'd1;
				end
				if (skip_n == 8'd0) begin
					phase_n = rle ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXEL;
				end
			end
			tgad_pkg::PH_PACKET: begin
				run_n   = data_byte[7];
				pkt_n   = cnt;
				bip_n   = 2'd0;
				phase_n = tgad_pkg::PH_PIXEL;
			end
			tgad_pkg::PH_PIXEL: begin
				if ({1'b0, bip} + 3'd1 < bpp) begin
					bip_n = bip + 2'd1;
				end else begin
					bip_n  = 2'd0;
					left_n = left_dec;
					if (rle) begin
						pkt_n = run ? 8'd0 : pkt_dec;
					end
					emit         = 1'b1;
					entry.status = tgad_pkg::ST_PIXEL;
					entry.rep    = rep;
					if (left_dec == 32'd0) begin
						entry.last = 1'b1;
						phase_n    = tgad_pkg::PH_DONE;
					end else if (rle && pkt_n == 8'd0) begin
						phase_n = tgad_pkg::PH_PACKET;
					end
				end
			end
			default: ;
		endcase
		if (!acc) begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tgad_pkg::PH_IDLE;
			hidx_q   <= '0;
			skip_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			depth_q  <= '0;
			alpha_q  <= '0;
			kind_q   <= '0;
			rle_q    <= 1'b0;
			left_q   <= '0;
			run_q    <= 1'b0;
			pkt_q    <= '0;
			bip_q    <= '0;
		end else if (acc) begin
			phase_q  <= phase_n;
			hidx_q   <= hidx_n;
			skip_q   <= skip_n;
			width_q  <= width_n;
			height_q <= height_n;
			depth_q  <= depth_n;
			alpha_q  <= alpha_n;
			kind_q   <= kind_n;
			rle_q    <= rle_n;
			left_q   <= left_n;
			run_q    <= run_n;
			pkt_q    <= pkt_n;
			bip_q    <= bip_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ph == tgad_pkg::PH_PIXEL) begin
			pb_q[bip] <= data_byte;
		end
	end

endmodule

>>> rtl/tgad_queue.sv
// ----------------------------------------------------------------------------
// tgad_queue
// Short queue of classified items between parser and formatter.
// ----------------------------------------------------------------------------
module tgad_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  tgad_pkg::entry_t wdata,
	input  logic             rd,
	output tgad_pkg::entry_t rdata,
	output logic             full,
	output logic             nonempty
);

	tgad_pkg::entry_t mem [tgad_pkg::QDepth];
	logic [tgad_pkg::QPtrW-1:0] wptr_q, rptr_q;
	logic [tgad_pkg::QPtrW:0]   cnt_q;

	assign full     = (cnt_q == (tgad_pkg::QPtrW+1)'(tgad_pkg::QDepth));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/tgad_back.sv
// ----------------------------------------------------------------------------
// tgad_back
// Result formatter: field masking, BGR(A) swap and output register.
// ----------------------------------------------------------------------------
module tgad_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_nonempty,
	input  tgad_pkg::entry_t q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [2:0]       status,
	output logic [15:0]      image_width,
	output logic [15:0]      image_height,
	output logic [5:0]       pixel_bits,
	output logic [3:0]       alpha_bits,
	output logic [1:0]       image_kind,
	output logic [7:0]       chan0,
	output logic [7:0]       chan1,
	output logic [7:0]       chan2,
	output logic [7:0]       chan3,
	output logic [7:0]       repeat_count,
	output logic             last_pixel
);

	logic            valid_q;
	tgad_pkg::entry_t fmt, out_q;
	logic [2:0]      bpp;

	assign q_rd  = q_nonempty && (!valid_q || pop);
	assign empty = !valid_q;

	always_comb begin
		bpp = q_data.depth[5:3];
		if (bpp == 3'd0) begin
			bpp = 3'd1;
		end else if (bpp > 3'd4) begin
			bpp = 3'd4;
		end
		fmt        = '0;
		fmt.status = q_data.status;
		fmt.last   = q_data.last;
		priority if (q_data.status == tgad_pkg::ST_PIXEL) begin
			for (int j = 0; j < 4; j++) begin
				if (j < int'(bpp)) begin
					fmt.bytes[j] = q_data.bytes[j];
				end
			end
			if (q_data.kind != tgad_pkg::KIND_GREY &&
			    (q_data.depth == 6'd24 || q_data.depth == 6'd32)) begin
				fmt.bytes[0] = q_data.bytes[2];
				fmt.bytes[2] = q_data.bytes[0];
			end
			fmt.rep = q_data.rep;
		end else if (q_data.status == tgad_pkg::ST_HEADER) begin
			fmt.width  = q_data.width;
			fmt.height = q_data.height;
			fmt.depth  = q_data.depth;
			fmt.alpha  = q_data.alpha;
			fmt.kind   = q_data.kind;
		end else begin
			fmt.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			out_q <= fmt;
		end
	end

	assign status       = out_q.status;
	assign image_width  = out_q.width;
	assign image_height = out_q.height;
	assign pixel_bits   = out_q.depth;
	assign alpha_bits   = out_q.alpha;
	assign image_kind   = out_q.kind;
	assign chan0        = out_q.bytes[0];
	assign chan1        = out_q.bytes[1];
	assign chan2        = out_q.bytes[2];
	assign chan3        = out_q.bytes[3];
	assign repeat_count = out_q.rep;
	assign last_pixel   = out_q.last;

endmodule

>>> rtl/tga_image_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_core
// TGA byte stream decoder: header result, errors and pixel/run results.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full, set by the parser update.
// A taken byte writes its result into the queue, from which it moves to the
//   output register when that is free.
// Image size product is formed by one 16x16 multiply on header byte 16.
// Reset: asynchronous, clears parser state and queue; no clearing pass.
module tga_image_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [5:0]  pixel_bits,
	output logic [3:0]  alpha_bits,
	output logic [1:0]  image_kind,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic [7:0]  chan3,
	output logic [7:0]  repeat_count,
	output logic        last_pixel
);

	logic             acc;
	logic             emit;
	tgad_pkg::entry_t f_entry;
	tgad_pkg::entry_t q_data;
	logic             q_rd;
	logic             q_nonempty;

	assign acc = push && !full;

	tgad_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.emit          (emit),
		.entry         (f_entry)
	);

	tgad_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (emit),
		.wdata    (f_entry),
		.rd       (q_rd),
		.rdata    (q_data),
		.full     (full),
		.nonempty (q_nonempty)
	);

	tgad_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_data       (q_data),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.status       (status),
		.image_width  (image_width),
		.image_height (image_height),
		.pixel_bits   (pixel_bits),
		.alpha_bits   (alpha_bits),
		.image_kind   (image_kind),
		.chan0        (chan0),
		.chan1        (chan1),
		.chan2        (chan2),
		.chan3        (chan3),
		.repeat_count (repeat_count),
		.last_pixel   (last_pixel)
	);

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && q_nonempty) |=> !empty)
		else $error("queued item not moved to output");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= tgad_pkg::ST_BAD_ALPHA))
		else $error("status code out of range");

	a_pixel_rep: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == tgad_pkg::ST_PIXEL) |-> (repeat_count != 8'd0))
		else $error("pixel item with zero repeat count");

	a_nonpixel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != tgad_pkg::ST_PIXEL) |->
		(repeat_count == 8'd0 && chan0 == 8'd0 && chan3 == 8'd0))
		else $error("pixel fields set in header or error item");

endmodule
